/* design/relu_dot_product_output_layer_top_defines.svh */
// Assertion macros shared by the output layer modules.
`ifndef RELU_DOT_PRODUCT_OUTPUT_LAYER_TOP_DEFINES_SVH
`define RELU_DOT_PRODUCT_OUTPUT_LAYER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDPOL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdpol: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RDPOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdpol: next-cycle check failed");

`endif

/* design/rdpol_pkg.sv */
`timescale 1ns / 1ps

package rdpol_pkg;

    localparam int INDEX_W    = 9;
    localparam int DATA_W     = 16;
    localparam int PAIR_W     = 2 * DATA_W;
    localparam int BIAS_W     = 27;
    localparam int BIAS_SHIFT = 5;
    localparam int PROD_W     = 31;
    localparam int SUM_W      = 48;
    localparam int TOTAL_W    = 49;
    localparam int OUT_SHIFT  = 14;
    localparam int QUOT_W     = TOTAL_W - OUT_SHIFT;
    localparam int SCORE_W    = 28;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W - 1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W - 1){1'b0}}};

    localparam logic OP_LOAD       = 1'b0;
    localparam logic OP_ACCUMULATE = 1'b1;

    typedef struct packed {
        logic                     valid;
        logic                     in_range;
        logic                     last;
        logic signed [DATA_W-1:0] stm_value;
        logic signed [DATA_W-1:0] xstm_value;
    } t_acc_beat;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
    } t_sum_beat;

endpackage

/* design/rdpol_weight_ram.sv */
`timescale 1ns / 1ps

module rdpol_weight_ram #(
    parameter int  DEPTH  = 512,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic [rdpol_pkg::PAIR_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic [rdpol_pkg::PAIR_W-1:0] o_rdata
);

    logic [rdpol_pkg::PAIR_W-1:0] r_mem [DEPTH];
    logic [rdpol_pkg::PAIR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rdpol_mac.sv */
`timescale 1ns / 1ps
`include "relu_dot_product_output_layer_top_defines.svh"

module rdpol_mac (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rdpol_pkg::t_acc_beat         i_acc,
    input  logic [rdpol_pkg::PAIR_W-1:0] i_weight_pair,
    output logic                         o_acc_ready,
    output rdpol_pkg::t_sum_beat         o_sum,
    input  logic                         i_sum_ready
);

    logic signed [rdpol_pkg::DATA_W-1:0] w_stm_weight;
    logic signed [rdpol_pkg::DATA_W-1:0] w_xstm_weight;
    logic signed [rdpol_pkg::DATA_W:0]   w_stm_act;
    logic signed [rdpol_pkg::DATA_W:0]   w_xstm_act;
    logic signed [rdpol_pkg::PROD_W+1:0] w_stm_full;
    logic signed [rdpol_pkg::PROD_W+1:0] w_xstm_full;
    logic                                r_prod_valid;
    logic                                r_prod_last;
    logic signed [rdpol_pkg::PROD_W-1:0] r_stm_prod;
    logic signed [rdpol_pkg::PROD_W-1:0] r_xstm_prod;
    logic signed [rdpol_pkg::SUM_W-1:0]  r_sum;
    logic signed [rdpol_pkg::SUM_W-1:0]  n_sum;
    rdpol_pkg::t_sum_beat                r_out;
    logic                                w_prod_take;
    logic                                w_out_free;

    assign w_stm_weight  = i_acc.in_range ? i_weight_pair[rdpol_pkg::DATA_W-1:0] : '0;
    assign w_xstm_weight = i_acc.in_range ?
                           i_weight_pair[rdpol_pkg::PAIR_W-1:rdpol_pkg::DATA_W] : '0;

    // Negative elements are clamped to zero; out-of-range indexes add nothing.
    assign w_stm_act  = (i_acc.in_range && !i_acc.stm_value[rdpol_pkg::DATA_W-1]) ?
                        {1'b0, i_acc.stm_value} : '0;
    assign w_xstm_act = (i_acc.in_range && !i_acc.xstm_value[rdpol_pkg::DATA_W-1]) ?
                        {1'b0, i_acc.xstm_value} : '0;

    assign w_stm_full  = w_stm_act * w_stm_weight;
    assign w_xstm_full = w_xstm_act * w_xstm_weight;

    assign n_sum = r_sum + rdpol_pkg::SUM_W'(r_stm_prod) + rdpol_pkg::SUM_W'(r_xstm_prod);

    assign w_out_free  = !r_out.valid || i_sum_ready;
    assign w_prod_take = r_prod_valid && (!r_prod_last || w_out_free);
    assign o_acc_ready = !r_prod_valid || w_prod_take;
    assign o_sum       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_sum        <= '0;
            r_out.valid  <= 1'b0;
        end else begin
            if (o_acc_ready) begin
                r_prod_valid <= i_acc.valid;
                r_prod_last  <= i_acc.last;
                r_stm_prod   <= w_stm_full[rdpol_pkg::PROD_W-1:0];
                r_xstm_prod  <= w_xstm_full[rdpol_pkg::PROD_W-1:0];
            end
            if (w_prod_take) begin
                r_sum <= r_prod_last ? '0 : n_sum;
            end
            if (w_prod_take && r_prod_last) begin
                r_out.valid <= 1'b1;
                r_out.sum   <= n_sum;
            end else if (i_sum_ready) begin
                r_out.valid <= 1'b0;
            end
        end
    end

    `RDPOL_ASSERT_NEXT(a_sum_cleared, i_clk, i_rst_n, w_prod_take && r_prod_last, r_sum == '0)
    `RDPOL_ASSERT_NEXT(a_last_beat_out, i_clk, i_rst_n, w_prod_take && r_prod_last, r_out.valid)

endmodule

/* design/rdpol_scale.sv */
`timescale 1ns / 1ps
`include "relu_dot_product_output_layer_top_defines.svh"

module rdpol_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rdpol_pkg::t_sum_beat                i_sum,
    output logic                                o_sum_ready,
    input  logic signed [rdpol_pkg::BIAS_W-1:0] i_output_bias,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rdpol_pkg::SCORE_W-1:0] o_score
);

    logic                                 r_total_valid;
    logic signed [rdpol_pkg::TOTAL_W-1:0] r_total;
    logic signed [rdpol_pkg::TOTAL_W-1:0] n_total;
    logic signed [rdpol_pkg::QUOT_W-1:0]  w_quot_floor;
    logic signed [rdpol_pkg::QUOT_W-1:0]  w_quot;
    logic                                 w_round_up;
    logic                                 w_fits;
    logic                                 w_total_take;
    logic                                 w_out_free;
    logic                                 r_out_valid;
    logic signed [rdpol_pkg::SCORE_W-1:0] r_score;
    logic signed [rdpol_pkg::SCORE_W-1:0] w_score_sat;
    logic                                 w_sign_ok;

    assign n_total = rdpol_pkg::TOTAL_W'(i_sum.sum)
                   + rdpol_pkg::TOTAL_W'($signed({i_output_bias,
                                                  {rdpol_pkg::BIAS_SHIFT{1'b0}}}));

    // Division toward zero: floor by shift, then step up for a negative value with a remainder.
    assign w_quot_floor = r_total[rdpol_pkg::TOTAL_W-1:rdpol_pkg::OUT_SHIFT];
    assign w_round_up   = r_total[rdpol_pkg::TOTAL_W-1] && (|r_total[rdpol_pkg::OUT_SHIFT-1:0]);
    assign w_quot       = w_quot_floor + {{(rdpol_pkg::QUOT_W - 1){1'b0}}, w_round_up};

    assign w_fits = (w_quot[rdpol_pkg::QUOT_W-1:rdpol_pkg::SCORE_W-1] == '0)
                 || (&w_quot[rdpol_pkg::QUOT_W-1:rdpol_pkg::SCORE_W-1]);
    assign w_score_sat = w_fits ? w_quot[rdpol_pkg::SCORE_W-1:0] :
                         (w_quot[rdpol_pkg::QUOT_W-1] ? rdpol_pkg::SCORE_MIN :
                                                        rdpol_pkg::SCORE_MAX);

    assign w_sign_ok = (w_score_sat[rdpol_pkg::SCORE_W-1] == r_total[rdpol_pkg::TOTAL_W-1])
                    || (w_score_sat == '0);

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_total_take = r_total_valid && w_out_free;
    assign o_sum_ready  = !r_total_valid || w_out_free;
    assign o_out_valid  = r_out_valid;
    assign o_score      = r_score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_sum_ready) begin
                r_total_valid <= i_sum.valid;
                r_total       <= n_total;
            end
            if (w_total_take) begin
                r_out_valid <= 1'b1;
                r_score     <= w_score_sat;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `RDPOL_ASSERT_NEXT(a_total_to_out, i_clk, i_rst_n, w_total_take, o_out_valid)
    `RDPOL_ASSERT_NOW(a_score_sign, i_clk, i_rst_n, r_total_valid, w_sign_ok)

endmodule

/* design/relu_dot_product_output_layer_top.sv */
// Quantized output layer: load beats store a signed weight pair at a hidden index, accumulate
// beats add relu(stm) * stm weight + relu(xstm) * xstm weight to a 48-bit running sum, and the
// accumulate beat marked last returns (bias * 32 + sum) / 16384, truncated toward zero and
// saturated to 28 bits, then clears the sum. The block takes one beat per cycle unless
// stalled, with no dependence between beats: the weight memory does one read or one write
// per cycle, and the add loop holds only the single sum register. A last beat passes the
// input, product, sum, total and score registers. The user must write the output bias on
// the configuration channel only while idle, not enforced by the block; it is always ready.
`timescale 1ns / 1ps
`include "relu_dot_product_output_layer_top_defines.svh"

module relu_dot_product_output_layer_top #(
    parameter int HIDDEN_SIZE = 512
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic signed [rdpol_pkg::BIAS_W-1:0]  i_cfg_output_bias,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_operation,
    input  logic [rdpol_pkg::INDEX_W-1:0]        i_index,
    input  logic signed [rdpol_pkg::DATA_W-1:0]  i_stm_value,
    input  logic signed [rdpol_pkg::DATA_W-1:0]  i_xstm_value,
    input  logic signed [rdpol_pkg::DATA_W-1:0]  i_stm_weight,
    input  logic signed [rdpol_pkg::DATA_W-1:0]  i_xstm_weight,
    input  logic                                 i_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rdpol_pkg::SCORE_W-1:0] o_score
);

    localparam int ADDR_W = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;

    logic signed [rdpol_pkg::BIAS_W-1:0] r_output_bias;
    rdpol_pkg::t_acc_beat                r_acc;
    rdpol_pkg::t_acc_beat                n_acc;
    logic                                w_accept;
    logic                                w_in_range;
    logic                                w_load_we;
    logic                                w_acc_take;
    logic                                w_acc_free;
    logic [ADDR_W-1:0]                   w_addr;
    logic [rdpol_pkg::PAIR_W-1:0]        w_weight_pair;
    rdpol_pkg::t_sum_beat                w_sum_beat;
    logic                                w_sum_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_bias <= '0;
        end else if (i_cfg_valid) begin
            r_output_bias <= i_cfg_output_bias;
        end
    end

    assign o_in_ready = !r_acc.valid || w_acc_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = 32'(i_index) < 32'(HIDDEN_SIZE);
    assign w_addr     = ADDR_W'(i_index);
    assign w_load_we  = w_accept && (i_operation == rdpol_pkg::OP_LOAD) && w_in_range;
    assign w_acc_take = w_accept && (i_operation == rdpol_pkg::OP_ACCUMULATE);

    always_comb begin
        n_acc = r_acc;
        if (w_acc_take) begin
            n_acc.valid      = 1'b1;
            n_acc.in_range   = w_in_range;
            n_acc.last       = i_last;
            n_acc.stm_value  = i_stm_value;
            n_acc.xstm_value = i_xstm_value;
        end else if (w_acc_free) begin
            n_acc.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc.valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
        end
    end

    rdpol_weight_ram #(
        .DEPTH (HIDDEN_SIZE)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (w_addr),
        .i_wdata ({i_xstm_weight, i_stm_weight}),
        .i_re    (w_acc_take),
        .i_raddr (w_addr),
        .o_rdata (w_weight_pair)
    );

    rdpol_mac u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (r_acc),
        .i_weight_pair (w_weight_pair),
        .o_acc_ready   (w_acc_free),
        .o_sum         (w_sum_beat),
        .i_sum_ready   (w_sum_ready)
    );

    rdpol_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sum         (w_sum_beat),
        .o_sum_ready   (w_sum_ready),
        .i_output_bias (r_output_bias),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_score       (o_score)
    );

    `RDPOL_ASSERT_NEXT(a_acc_enters, i_clk, i_rst_n, w_acc_take, r_acc.valid)

endmodule

/* test/tb_relu_dot_product_output_layer_top.sv */
`timescale 1ns / 1ps

module tb_relu_dot_product_output_layer_top;

    localparam int HIDDEN         = 512;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;

    typedef struct {
        logic                                op;
        logic [rdpol_pkg::INDEX_W-1:0]       index;
        logic signed [rdpol_pkg::DATA_W-1:0] stm_value;
        logic signed [rdpol_pkg::DATA_W-1:0] xstm_value;
        logic signed [rdpol_pkg::DATA_W-1:0] stm_weight;
        logic signed [rdpol_pkg::DATA_W-1:0] xstm_weight;
        logic                                last;
    } t_beat;

    logic                                 i_clk;
    logic                                 i_rst_n           = 1'b0;
    logic                                 i_cfg_valid       = 1'b0;
    logic                                 o_cfg_ready;
    logic signed [rdpol_pkg::BIAS_W-1:0]  i_cfg_output_bias = '0;
    logic                                 i_in_valid        = 1'b0;
    logic                                 o_in_ready;
    logic                                 i_operation       = rdpol_pkg::OP_LOAD;
    logic [rdpol_pkg::INDEX_W-1:0]        i_index           = '0;
    logic signed [rdpol_pkg::DATA_W-1:0]  i_stm_value       = '0;
    logic signed [rdpol_pkg::DATA_W-1:0]  i_xstm_value      = '0;
    logic signed [rdpol_pkg::DATA_W-1:0]  i_stm_weight      = '0;
    logic signed [rdpol_pkg::DATA_W-1:0]  i_xstm_weight     = '0;
    logic                                 i_last            = 1'b0;
    logic                                 o_out_valid;
    logic                                 i_out_ready       = 1'b0;
    logic signed [rdpol_pkg::SCORE_W-1:0] o_score;

    t_beat                                beat_queue[$];
    logic signed [rdpol_pkg::SCORE_W-1:0] expected_scores[$];
    int                                   loaded_list[$];
    bit                                   loaded_map[HIDDEN];

    logic signed [rdpol_pkg::DATA_W-1:0]  weight_stm[HIDDEN];
    logic signed [rdpol_pkg::DATA_W-1:0]  weight_xstm[HIDDEN];
    logic signed [rdpol_pkg::SUM_W-1:0]   dot_sum;
    logic signed [rdpol_pkg::BIAS_W-1:0]  bias_now;

    logic                                 idle_enable  = 1'b1;
    logic                                 hold_request = 1'b0;
    int                                   send_gap;
    int                                   stall_left;
    int                                   hold_left;
    bit                                   hold_done;
    int                                   quiet_cycles;
    int                                   fail_count;
    int                                   beats_seen;
    int                                   scores_checked;
    int                                   bias_writes;
    t_beat                                seen_beat;
    logic signed [rdpol_pkg::SCORE_W-1:0] predicted;
    logic signed [rdpol_pkg::SCORE_W-1:0] wanted;

    relu_dot_product_output_layer_top #(
        .HIDDEN_SIZE(HIDDEN)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_output_bias(i_cfg_output_bias),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_index          (i_index),
        .i_stm_value      (i_stm_value),
        .i_xstm_value     (i_xstm_value),
        .i_stm_weight     (i_stm_weight),
        .i_xstm_weight    (i_xstm_weight),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_score          (o_score)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic bit score_for_beat(input t_beat b,
                                          output logic signed [rdpol_pkg::SCORE_W-1:0] s);
        longint add;
        longint total;
        longint q;
        add = 0;
        s = '0;
        if (b.op == rdpol_pkg::OP_LOAD) begin
            if (b.index < HIDDEN) begin
                weight_stm[b.index]  = b.stm_weight;
                weight_xstm[b.index] = b.xstm_weight;
            end
            return 1'b0;
        end
        if (b.index < HIDDEN) begin
            if (b.stm_value > 0) begin
                add += longint'(b.stm_value) * longint'(weight_stm[b.index]);
            end
            if (b.xstm_value > 0) begin
                add += longint'(b.xstm_value) * longint'(weight_xstm[b.index]);
            end
            dot_sum = rdpol_pkg::SUM_W'(longint'(dot_sum) + add);
        end
        if (!b.last) begin
            return 1'b0;
        end
        total = longint'(bias_now) * 32 + longint'(dot_sum);
        q = total / 16384;
        if (q > longint'(rdpol_pkg::SCORE_MAX)) begin
            q = longint'(rdpol_pkg::SCORE_MAX);
        end
        if (q < longint'(rdpol_pkg::SCORE_MIN)) begin
            q = longint'(rdpol_pkg::SCORE_MIN);
        end
        s = q[rdpol_pkg::SCORE_W-1:0];
        dot_sum = '0;
        return 1'b1;
    endfunction

    function automatic logic signed [rdpol_pkg::DATA_W-1:0] pick_data();
        case ($urandom_range(0, 7))
            0: begin
                return 16'sh7FFF;
            end
            1: begin
                return 16'sh8000;
            end
            2: begin
                return '0;
            end
            default: begin
                return rdpol_pkg::DATA_W'($urandom());
            end
        endcase
    endfunction

    task automatic push_load(input int idx, input logic signed [rdpol_pkg::DATA_W-1:0] sw,
                             input logic signed [rdpol_pkg::DATA_W-1:0] xw, input logic lst);
        t_beat b;
        b.op          = rdpol_pkg::OP_LOAD;
        b.index       = rdpol_pkg::INDEX_W'(idx);
        b.stm_value   = rdpol_pkg::DATA_W'($urandom());
        b.xstm_value  = rdpol_pkg::DATA_W'($urandom());
        b.stm_weight  = sw;
        b.xstm_weight = xw;
        b.last        = lst;
        beat_queue.push_back(b);
        if (!loaded_map[idx]) begin
            loaded_map[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endtask

    task automatic push_acc(input int idx, input logic signed [rdpol_pkg::DATA_W-1:0] sv,
                            input logic signed [rdpol_pkg::DATA_W-1:0] xv, input logic lst);
        t_beat b;
        b.op          = rdpol_pkg::OP_ACCUMULATE;
        b.index       = rdpol_pkg::INDEX_W'(idx);
        b.stm_value   = sv;
        b.xstm_value  = xv;
        b.stm_weight  = rdpol_pkg::DATA_W'($urandom());
        b.xstm_weight = rdpol_pkg::DATA_W'($urandom());
        b.last        = lst;
        beat_queue.push_back(b);
    endtask

    task automatic queue_random_traffic(input int n, input int max_len);
        int made;
        int len;
        int k;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 4) == 0) begin
                push_load($urandom_range(0, HIDDEN - 1), pick_data(), pick_data(),
                          1'($urandom()));
                made++;
            end else begin
                len = $urandom_range(1, max_len);
                for (k = 0; k < len; k++) begin
                    push_acc(loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                             pick_data(), pick_data(),
                             (k == len - 1) && ($urandom_range(0, 7) != 0));
                    made++;
                end
            end
        end
    endtask

    task automatic queue_stream(input int idx, input int count);
        int k;
        for (k = 0; k < count; k++) begin
            push_acc(idx, 16'sh7FFF, 16'sh7FFF, k == count - 1);
        end
    endtask

    task automatic wait_idle();
        while (beat_queue.size() != 0 || i_in_valid || expected_scores.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_bias(input logic signed [rdpol_pkg::BIAS_W-1:0] value);
        i_cfg_output_bias <= value;
        i_cfg_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_beat b;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (send_gap != 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 11) == 0) begin
                send_gap   <= $urandom_range(0, 14);
                i_in_valid <= 1'b0;
            end else if (beat_queue.size() != 0) begin
                b = beat_queue.pop_front();
                i_operation   <= b.op;
                i_index       <= b.index;
                i_stm_value   <= b.stm_value;
                i_xstm_value  <= b.xstm_value;
                i_stm_weight  <= b.stm_weight;
                i_xstm_weight <= b.xstm_weight;
                i_last        <= b.last;
                i_in_valid    <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_left   <= LONG_HOLD - 1;
            hold_done   <= 1'b1;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 11) == 0) begin
            stall_left  <= $urandom_range(0, 14);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dot_sum  = '0;
            bias_now = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                bias_now = i_cfg_output_bias;
                bias_writes++;
            end
            if (i_in_valid && o_in_ready) begin
                seen_beat.op          = i_operation;
                seen_beat.index       = i_index;
                seen_beat.stm_value   = i_stm_value;
                seen_beat.xstm_value  = i_xstm_value;
                seen_beat.stm_weight  = i_stm_weight;
                seen_beat.xstm_weight = i_xstm_weight;
                seen_beat.last        = i_last;
                beats_seen++;
                if (score_for_beat(seen_beat, predicted)) begin
                    expected_scores.push_back(predicted);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_scores.size() == 0) begin
                    report_mismatch($sformatf("score %0d with none expected", o_score));
                end else begin
                    wanted = expected_scores.pop_front();
                    scores_checked++;
                    if (o_score !== wanted) begin
                        report_mismatch($sformatf("score %0d, expected %0d", o_score, wanted));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_load(0, 16'sh7FFF, 16'sh8000, 1'b0);
        push_load(511, 16'sh8000, 16'sh7FFF, 1'b0);
        push_load(1, 16'sh7FFF, 16'sh7FFF, 1'b0);
        push_load(2, -16'sd1, 16'sd1, 1'b0);
        push_load(3, 16'sd0, 16'sd0, 1'b1);
        push_acc(0, 16'sh7FFF, 16'sh7FFF, 1'b0);
        push_acc(511, 16'sh8000, 16'sh7FFF, 1'b0);
        push_acc(1, 16'sh7FFF, 16'sh7FFF, 1'b1);
        push_acc(2, 16'sd0, -16'sd1, 1'b1);
        push_acc(2, 16'sd1, 16'sd1, 1'b1);
        push_acc(3, 16'sh8000, 16'sh8000, 1'b1);
        push_acc(1, -16'sd1, -16'sd1, 1'b0);
        push_acc(0, 16'sd1, 16'sh7FFF, 1'b1);
        push_acc(511, 16'sh7FFF, 16'sd1, 1'b1);
        push_acc(0, 16'sh7FFF, 16'sd0, 1'b1);
        wait_idle();

        write_bias(27'sh3FFFFFF);
        queue_random_traffic(300, 16);
        wait_idle();

        write_bias(27'sh4000000);
        queue_random_traffic(300, 3);
        hold_request <= 1'b1;
        wait_idle();

        write_bias(rdpol_pkg::BIAS_W'($urandom()));
        queue_random_traffic(250, 24);
        wait_idle();

        idle_enable <= 1'b0;
        write_bias(27'sh3FFFFFF);
        push_load(6, 16'sh7FFF, 16'sh7FFF, 1'b0);
        push_load(7, 16'sh8000, 16'sh8000, 1'b0);
        queue_stream(6, 20);
        wait_idle();

        write_bias(27'sh4000000);
        queue_stream(7, 20);
        wait_idle();

        write_bias(-27'sd1);
        queue_random_traffic(60, 8);
        wait_idle();

        write_bias(27'sd1);
        queue_random_traffic(60, 8);
        wait_idle();

        if (expected_scores.size() != 0) begin
            report_mismatch($sformatf("%0d scores never arrived", expected_scores.size()));
        end
        $display("summary: %0d input beats, %0d scores checked, %0d bias writes",
                 beats_seen, scores_checked, bias_writes);
        $display("summary: covered relu clamping, rounding toward zero, extreme biases and stalls");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/rdpol_pkg.sv
design/rdpol_weight_ram.sv
design/rdpol_mac.sv
design/rdpol_scale.sv
design/relu_dot_product_output_layer_top.sv
test/tb_relu_dot_product_output_layer_top.sv
